// ===== design/assert_macros.svh =====
// Concurrent assertion helpers, clocked on the rising edge, off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LPS_ASSERT(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: expression does not hold");

`define LPS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");

`endif

// ===== design/lps_pkg.sv =====
package lps_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned KeyW     = 8;
  localparam int unsigned ModeW    = 4;
  localparam int unsigned StepW    = 5;
  localparam int unsigned TickW    = 16;
  localparam int unsigned DataOutW = 32;

  localparam logic [CfgIdxW-1:0] RegFlashHalf  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegShiftStep  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSpreadStep = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAuxStep    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAuxDuty    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRampStep   = 3'd5;

  localparam logic [TickW-1:0] FlashHalfRst  = 16'd500;
  localparam logic [TickW-1:0] ShiftStepRst  = 16'd250;
  localparam logic [TickW-1:0] SpreadStepRst = 16'd300;
  localparam logic [TickW-1:0] AuxStepRst    = 16'd100;
  localparam logic [7:0]       AuxDutyRst    = 8'd100;
  localparam logic [TickW-1:0] RampStepRst   = 16'd4;

  localparam logic [ModeW-1:0] ModeIdle     = 4'd0;
  localparam logic [ModeW-1:0] ModeFlash    = 4'd1;
  localparam logic [ModeW-1:0] ModeLeft     = 4'd2;
  localparam logic [ModeW-1:0] ModeRight    = 4'd3;
  localparam logic [ModeW-1:0] ModeAux      = 4'd4;
  localparam logic [ModeW-1:0] ModeDiverge  = 4'd5;
  localparam logic [ModeW-1:0] ModeConverge = 4'd6;
  localparam logic [ModeW-1:0] ModePingPong = 4'd7;
  localparam logic [ModeW-1:0] ModeFill     = 4'd8;
  localparam logic [ModeW-1:0] ModeRamp     = 4'd9;

  localparam logic [KeyW-1:0] KeyOne    = 8'h31;
  localparam logic [KeyW-1:0] KeyNine   = 8'h39;
  localparam logic [3:0]      KeyDigitHi = 4'h3;

  localparam logic [7:0] LedsAllOn  = 8'hff;
  localparam logic [7:0] LedsAllOff = 8'h00;
  localparam logic [7:0] DutyMax    = 8'd255;
  localparam logic [7:0] DutyTurn   = 8'd254;

  localparam logic [StepW-1:0] StepsFlash = 5'd2;
  localparam logic [StepW-1:0] StepsAux   = 5'd3;
  localparam logic [StepW-1:0] StepsSpread = 5'd4;
  localparam logic [StepW-1:0] StepsPing  = 5'd16;
  localparam logic [StepW-1:0] StepsWalk  = 5'd8;
  localparam logic [StepW-1:0] FillLast   = 5'd7;

  typedef struct packed {
    logic [ModeW-1:0] active_pattern;
    logic             bypass_on;
    logic [7:0]       pwm_duty;
    logic             pwm_enable;
    logic [2:0]       aux_leds;
    logic             led_port_driven;
    logic [7:0]       led_port;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

// ===== design/led_pattern_sequencer_unit.sv =====
// LED pattern sequencer. Each request on the slave stream is either a time
// tick (tuser 0) or a key press (tuser 1, ASCII code in tdata), and yields
// exactly one status word on the master stream. A request is accepted in
// every cycle while the skid register is empty: the pattern state is updated
// in a single pass of short logic, and the result lands in an output register
// backed by a one-entry skid register, so the slave side stays ready while
// one result waits on a stalled master side; tready drops only when both are
// full. The user writes step lengths and the pattern-four duty through the
// cfg_* port only while the stream is quiet; the block does not enforce it.
`include "assert_macros.svh"

module led_pattern_sequencer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [lps_pkg::KeyW-1:0]       s_axis_tdata_i,   // [7:0] key_code
  input  logic                           s_axis_tuser_i,   // [0] action
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [7:0] led_port, [8] led_port_driven, [11:9] aux_leds, [12] pwm_enable,
  // [20:13] pwm_duty, [21] bypass_on, [25:22] active_pattern, [31:26] zero
  output logic [lps_pkg::DataOutW-1:0]   m_axis_tdata_o,
  input  logic                           cfg_we_i,
  input  logic [lps_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lps_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [lps_pkg::TickW-1:0] flash_half_q, shift_step_q, spread_step_q;
  logic [lps_pkg::TickW-1:0] aux_step_q, ramp_step_q;
  logic [7:0]                aux_duty_q;

  logic [lps_pkg::ModeW-1:0] mode_q, mode_d;
  logic [lps_pkg::StepW-1:0] step_q, step_d;
  logic [lps_pkg::TickW-1:0] tick_q, tick_d;
  logic                      pend_valid_q, pend_valid_d;
  logic [lps_pkg::KeyW-1:0]  pend_key_q, pend_key_d;
  logic [7:0]                ramp_q, ramp_d;
  logic                      falling_q, falling_d;
  logic [7:0]                leds_q, leds_d;
  logic [2:0]                aux_q, aux_d;
  logic [7:0]                duty_q, duty_d;

  logic                      in_fire;
  logic                      do_begin;
  logic [lps_pkg::TickW-1:0] period;
  logic [lps_pkg::StepW-1:0] steps;
  logic [lps_pkg::StepW-1:0] step_nx;
  logic [2:0]                s_nx;
  logic                      pwm;
  lps_pkg::result_t          res;

  logic                      out_valid_q, skid_valid_q;
  lps_pkg::result_t          out_q, skid_q;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_half_q  <= lps_pkg::FlashHalfRst;
      shift_step_q  <= lps_pkg::ShiftStepRst;
      spread_step_q <= lps_pkg::SpreadStepRst;
      aux_step_q    <= lps_pkg::AuxStepRst;
      aux_duty_q    <= lps_pkg::AuxDutyRst;
      ramp_step_q   <= lps_pkg::RampStepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lps_pkg::RegFlashHalf:  flash_half_q  <= cfg_data_i;
        lps_pkg::RegShiftStep:  shift_step_q  <= cfg_data_i;
        lps_pkg::RegSpreadStep: spread_step_q <= cfg_data_i;
        lps_pkg::RegAuxStep:    aux_step_q    <= cfg_data_i;
        lps_pkg::RegAuxDuty:    aux_duty_q    <= cfg_data_i[7:0];
        lps_pkg::RegRampStep:   ramp_step_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mode_q)
      lps_pkg::ModeFlash: period = flash_half_q;
      lps_pkg::ModeLeft, lps_pkg::ModeRight, lps_pkg::ModePingPong: period = shift_step_q;
      lps_pkg::ModeAux: period = aux_step_q;
      lps_pkg::ModeRamp: period = ramp_step_q;
      default: period = spread_step_q;
    endcase
    unique case (mode_q)
      lps_pkg::ModeFlash: steps = lps_pkg::StepsFlash;
      lps_pkg::ModeAux: steps = lps_pkg::StepsAux;
      lps_pkg::ModeDiverge, lps_pkg::ModeConverge: steps = lps_pkg::StepsSpread;
      lps_pkg::ModePingPong: steps = lps_pkg::StepsPing;
      default: steps = lps_pkg::StepsWalk;
    endcase
  end

  always_comb begin
    mode_d       = mode_q;
    step_d       = step_q;
    tick_d       = tick_q;
    pend_valid_d = pend_valid_q;
    pend_key_d   = pend_key_q;
    ramp_d       = ramp_q;
    falling_d    = falling_q;
    leds_d       = leds_q;
    aux_d        = aux_q;
    duty_d       = duty_q;
    do_begin     = 1'b0;
    step_nx      = step_q + 5'd1;

    if (in_fire) begin
      if (s_axis_tuser_i) begin
        if (mode_q == lps_pkg::ModeIdle) begin
          if (s_axis_tdata_i >= lps_pkg::KeyOne && s_axis_tdata_i <= lps_pkg::KeyNine) begin
            mode_d       = s_axis_tdata_i[3:0];
            step_d       = '0;
            tick_d       = '0;
            pend_valid_d = 1'b0;
            ramp_d       = '0;
            falling_d    = 1'b0;
            if (mode_d == lps_pkg::ModeRamp) begin
              duty_d = '0;
            end else begin
              do_begin = 1'b1;
            end
          end
        end else if (!pend_valid_q) begin
          pend_valid_d = 1'b1;
          pend_key_d   = s_axis_tdata_i;
        end
      end else if (mode_q != lps_pkg::ModeIdle) begin
        if ({1'b0, tick_q} + 17'd1 < {1'b0, period}) begin
          tick_d = tick_q + 16'd1;
        end else begin
          tick_d = '0;
          if (mode_q == lps_pkg::ModeRamp) begin
            if (!falling_q) begin
              if (ramp_q >= lps_pkg::DutyTurn) begin
                ramp_d    = lps_pkg::DutyMax;
                falling_d = 1'b1;
              end else begin
                ramp_d = ramp_q + 8'd1;
              end
            end else if (ramp_q <= 8'd1) begin
              ramp_d       = '0;
              falling_d    = 1'b0;
              pend_valid_d = 1'b0;
            end else begin
              ramp_d = ramp_q - 8'd1;
            end
            duty_d = ramp_d;
          end else begin
            unique case (mode_q)
              lps_pkg::ModeLeft, lps_pkg::ModeRight, lps_pkg::ModeDiverge,
              lps_pkg::ModeConverge, lps_pkg::ModePingPong: leds_d = lps_pkg::LedsAllOff;
              lps_pkg::ModeAux: aux_d = aux_q | (3'd1 << step_q[1:0]);
              lps_pkg::ModeFill: begin
                if (step_q >= lps_pkg::FillLast) leds_d = lps_pkg::LedsAllOff;
              end
              default: ;
            endcase
            do_begin = 1'b1;
            if (step_nx >= steps) begin
              step_nx = '0;
              if (pend_valid_q) begin
                pend_valid_d = 1'b0;
                if (pend_key_q > {lps_pkg::KeyDigitHi, mode_q}) begin
                  if (mode_q == lps_pkg::ModeAux) aux_d = '0;
                  mode_d   = lps_pkg::ModeIdle;
                  do_begin = 1'b0;
                end
              end
            end
            step_d = step_nx;
          end
        end
      end
    end

    s_nx = step_d[2:0];
    if (do_begin) begin
      unique case (mode_d)
        lps_pkg::ModeFlash:
          leds_d = (step_d != '0) ? lps_pkg::LedsAllOff : lps_pkg::LedsAllOn;
        lps_pkg::ModeLeft: leds_d = 8'd1 << s_nx;
        lps_pkg::ModeRight: leds_d = 8'h80 >> s_nx;
        lps_pkg::ModeAux: begin
          if (step_d == '0) duty_d = aux_duty_q;
          aux_d = aux_d & ~(3'd1 << step_d[1:0]);
        end
        lps_pkg::ModeDiverge:
          leds_d = (8'd1 << (3'd3 - s_nx)) | (8'd1 << (3'd4 + s_nx));
        lps_pkg::ModeConverge: leds_d = (8'd1 << s_nx) | (8'h80 >> s_nx);
        lps_pkg::ModePingPong:
          leds_d = (step_d < 5'd8) ? (8'd1 << s_nx) : (8'h80 >> s_nx);
        lps_pkg::ModeFill: leds_d = leds_d | (8'd1 << s_nx);
        default: ;
      endcase
    end

    pwm                 = (mode_d == lps_pkg::ModeAux) || (mode_d == lps_pkg::ModeRamp);
    res.led_port        = leds_d;
    res.led_port_driven = !pwm;
    res.aux_leds        = aux_d;
    res.pwm_enable      = pwm;
    res.pwm_duty        = duty_d;
    res.bypass_on       = pwm;
    res.active_pattern  = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= lps_pkg::ModeIdle;
      step_q       <= '0;
      tick_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_key_q   <= '0;
      ramp_q       <= '0;
      falling_q    <= 1'b0;
      leds_q       <= '0;
      aux_q        <= '0;
      duty_q       <= '0;
    end else begin
      mode_q       <= mode_d;
      step_q       <= step_d;
      tick_q       <= tick_d;
      pend_valid_q <= pend_valid_d;
      pend_key_q   <= pend_key_d;
      ramp_q       <= ramp_d;
      falling_q    <= falling_d;
      leds_q       <= leds_d;
      aux_q        <= aux_d;
      duty_q       <= duty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(lps_pkg::DataOutW - lps_pkg::ResultW){1'b0}}, out_q};

  `LPS_ASSERT(a_skid_needs_out, clk_i, rst_ni, !skid_valid_q || out_valid_q)
  `LPS_ASSERT(a_mode_range, clk_i, rst_ni, mode_q <= lps_pkg::ModeRamp)
  `LPS_ASSERT_IMPL(a_pend_only_running, clk_i, rst_ni, pend_valid_q, mode_q != lps_pkg::ModeIdle)
  `LPS_ASSERT_IMPL(a_step_bound, clk_i, rst_ni, mode_q != lps_pkg::ModePingPong, step_q < 5'd8)

endmodule
